// ===== hw/rtl/knn_pkg.sv =====
`default_nettype none
package knn_pkg;
   localparam int TRAIN_DEPTH  = 1024;
   localparam int ADDR_W       = $clog2(TRAIN_DEPTH);
   localparam int CNT_W        = $clog2(TRAIN_DEPTH + 1);
   localparam int NUM_FEATURES = 8;
   localparam int NF_W         = 4;
   localparam int MAX_K        = 16;
   localparam int K_W          = 5;
   localparam int POS_W        = 4;
   localparam int FEAT_W       = 16;
   localparam int SQ_W         = 32;
   localparam int DIST_W       = 35;
   localparam int LABEL_W      = 8;
   localparam int ROW_W        = NUM_FEATURES * FEAT_W + LABEL_W;

   localparam logic [1:0] CMD_CLEAR    = 2'd0;
   localparam logic [1:0] CMD_ADD      = 2'd1;
   localparam logic [1:0] CMD_CLASSIFY = 2'd2;

   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_K_BIG = 2'd1;
   localparam logic [1:0] STATUS_EMPTY = 2'd2;
   localparam logic [1:0] STATUS_FULL  = 2'd3;

   localparam logic REG_NEIGHBOR_COUNT  = 1'b0;
   localparam logic REG_FEATURES_IN_USE = 1'b1;

   typedef logic [LABEL_W-1:0] label_arr_type [MAX_K];

   typedef struct packed {
      logic                valid;
      logic [DIST_W-1:0]   sq_dist;
      logic [LABEL_W-1:0]  label;
   } cand_type;
endpackage
`default_nettype wire

// ===== hw/rtl/knn_lane.sv =====
`default_nettype none
module knn_lane import knn_pkg::*; (
   input  wire                     clock,
   input  wire                     in_use,
   input  wire signed [FEAT_W-1:0] query,
   input  wire signed [FEAT_W-1:0] stored,
   output logic [SQ_W-1:0]         sq_ff
);
   logic signed [FEAT_W:0]     diff;
   logic signed [2*FEAT_W+1:0] prod;
   logic [SQ_W-1:0]            sq_in;

   always_comb begin
      diff  = {query[FEAT_W-1], query} - {stored[FEAT_W-1], stored};
      prod  = diff * diff;
      // square of a 17-bit difference fits in 32 bits
      sq_in = in_use ? prod[SQ_W-1:0] : '0;
   end

   always_ff @(posedge clock) begin
      sq_ff <= sq_in;
   end
endmodule
`default_nettype wire

// ===== hw/rtl/knn_rank.sv =====
`default_nettype none
module knn_rank import knn_pkg::*; (
   input  wire            clock,
   input  wire            reset,
   input  wire            clear,
   input  cand_type       cand,
   input  wire [K_W-1:0]  k_eff,
   output label_arr_type  labels,
   output logic [K_W-1:0] fill_ff
);
   logic [DIST_W-1:0]  dist_ff [MAX_K];
   logic [LABEL_W-1:0] lab_ff  [MAX_K];
   logic [K_W-1:0]     fill_in;
   logic [POS_W-1:0]   pos;
   logic               hit;

   // first slot the candidate beats; ties keep the earlier entry
   always_comb begin
      pos = '0;
      hit = 1'b0;
      for (int p = MAX_K - 1; p >= 0; p--) begin
         if ((K_W'(p) < k_eff) &&
             ((K_W'(p) >= fill_ff) || (cand.sq_dist < dist_ff[p]))) begin
            pos = POS_W'(p);
            hit = 1'b1;
         end
      end
      fill_in = fill_ff;
      if (clear)
         fill_in = '0;
      else if (cand.valid && fill_ff < k_eff)
         fill_in = fill_ff + 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset)
         fill_ff <= '0;
      else
         fill_ff <= fill_in;
   end

   always_ff @(posedge clock) begin
      if (cand.valid && hit && !clear) begin
         for (int p = 0; p < MAX_K; p++) begin
            if (POS_W'(p) == pos) begin
               dist_ff[p] <= cand.sq_dist;
               lab_ff[p]  <= cand.label;
            end else if (POS_W'(p) > pos && p > 0) begin
               dist_ff[p] <= dist_ff[p-1];
               lab_ff[p]  <= lab_ff[p-1];
            end
         end
      end
   end

   always_comb begin
      for (int p = 0; p < MAX_K; p++)
         labels[p] = lab_ff[p];
   end
endmodule
`default_nettype wire

// ===== hw/rtl/knn_vote.sv =====
`default_nettype none
module knn_vote import knn_pkg::*; (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 start,
   input  wire [K_W-1:0]       fill,
   input  label_arr_type       labels,
   output logic                done_ff,
   output logic [LABEL_W-1:0]  class_ff
);
   logic               busy_ff, busy_in, done_in;
   logic [POS_W-1:0]   j_ff, j_in;
   logic [K_W-1:0]     best_ff, best_in, votes;
   logic [LABEL_W-1:0] class_in;

   always_comb begin
      votes = '0;
      for (int m = 0; m < MAX_K; m++)
         if (K_W'(m) < fill && labels[m] == labels[j_ff])
            votes = votes + 1'b1;
      busy_in  = busy_ff;
      j_in     = j_ff;
      best_in  = best_ff;
      class_in = class_ff;
      done_in  = 1'b0;
      if (start) begin
         busy_in  = 1'b1;
         j_in     = '0;
         best_in  = '0;
         class_in = '0;
      end else if (busy_ff) begin
         if (votes > best_ff) begin
            best_in  = votes;
            class_in = labels[j_ff];
         end
         j_in = j_ff + 1'b1;
         if ({1'b0, j_ff} == fill - 1'b1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      j_ff     <= j_in;
      best_ff  <= best_in;
      class_ff <= class_in;
   end
endmodule
`default_nettype wire

// ===== hw/rtl/knn_majority_classifier.sv =====
`default_nettype none
// k-nearest-neighbour classifier with a 1024-entry training store.
// Request channel (req_*): command, eight signed Q8.8 features, class label.
//   clear - empties the store, no response.
//   add   - appends an example; response class 0, status ok or full.
//   classify - ranks every stored example by squared distance, k nearest vote.
// Response channel (rsp_*): predicted class and status, one register deep.
// csr_* writes k (index 0) and features in use (index 1); the user must write
// them only while idle, the block does not enforce it. A classify request
// scans every stored row, drains the pipeline, votes and then loads the
// response; no new request is taken before that. The scan rate is set by the
// single read port of the training memory, one row (eight features,
// lane-parallel) a cycle.
// Errors (empty store, k above stored count) and adds load the response at
// the accept edge; it is valid the next cycle.
// A new request is taken while the response register is free or being taken;
// a stalled receiver holds the response and blocks further requests.
// Reset empties the store and sets k to 1 and features in use to 8; the
// memory contents are not cleared.
module knn_majority_classifier import knn_pkg::*; (
   input  wire          clock,
   input  wire          reset,
   input  wire          req_tvalid,
   output logic         req_tready,
   // command[1:0], feature_0..feature_7 [129:2], class_label [137:130]
   input  wire  [143:0] req_tdata,
   output logic         rsp_tvalid,
   input  wire          rsp_tready,
   // predicted_class [7:0], status [9:8]
   output logic [15:0]  rsp_tdata,
   input  wire          csr_we,
   input  wire          csr_index,
   input  wire  [4:0]   csr_wdata
);
   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_SCAN  = 3'd1;
   localparam logic [2:0] ST_DRAIN = 3'd2;
   localparam logic [2:0] ST_VOTE  = 3'd3;
   localparam logic [2:0] ST_DONE  = 3'd4;

   logic [2:0]          state_ff, state_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [ADDR_W-1:0]   scan_ff, scan_in;
   logic [K_W-1:0]      kreg_ff, kreg_in, keff_ff, keff_in, k_sat;
   logic [NF_W-1:0]     nfreg_ff, nfreg_in, nf_ff, nf_in;
   logic [FEAT_W-1:0]   query_ff [NUM_FEATURES];
   logic [ROW_W-1:0]    store_mem [TRAIN_DEPTH];
   logic [ROW_W-1:0]    rd_ff;
   logic                v1_ff, v2_ff, v3_ff;
   logic [LABEL_W-1:0]  lab2_ff, lab3_ff;
   logic [SQ_W-1:0]     sq [NUM_FEATURES];
   logic [DIST_W-1:0]   dist_ff, dist_sum;
   logic                rsp_valid_ff, rsp_valid_in, rsp_load;
   logic [LABEL_W-1:0]  rsp_class_ff, rsp_class_in;
   logic [1:0]          rsp_status_ff, rsp_status_in;
   logic                accept, do_add, rank_clear, vote_start, vote_done;
   logic [1:0]          cmd;
   logic [LABEL_W-1:0]  vote_class;
   logic [K_W-1:0]      fill;
   label_arr_type       labels;
   cand_type            cand;

   assign cmd        = req_tdata[1:0];
   assign req_tready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_tready);
   assign accept     = req_tvalid && req_tready;
   assign do_add     = accept && cmd == CMD_ADD && count_ff < CNT_W'(TRAIN_DEPTH);

   always_comb begin
      if (kreg_ff == '0)
         k_sat = K_W'(1);
      else if (kreg_ff > K_W'(MAX_K))
         k_sat = K_W'(MAX_K);
      else
         k_sat = kreg_ff;
   end

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      scan_in       = scan_ff;
      keff_in       = keff_ff;
      nf_in         = nf_ff;
      kreg_in       = kreg_ff;
      nfreg_in      = nfreg_ff;
      rsp_load      = 1'b0;
      rsp_class_in  = rsp_class_ff;
      rsp_status_in = rsp_status_ff;
      rank_clear    = 1'b0;
      vote_start    = 1'b0;
      if (csr_we) begin
         case (csr_index)
            REG_NEIGHBOR_COUNT:  kreg_in  = csr_wdata;
            REG_FEATURES_IN_USE: nfreg_in = csr_wdata[NF_W-1:0];
            default: ;
         endcase
      end
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (cmd)
                  CMD_CLEAR: count_in = '0;
                  CMD_ADD: begin
                     rsp_load      = 1'b1;
                     rsp_class_in  = '0;
                     rsp_status_in = do_add ? STATUS_OK : STATUS_FULL;
                     if (do_add)
                        count_in = count_ff + 1'b1;
                  end
                  CMD_CLASSIFY: begin
                     keff_in  = k_sat;
                     nf_in    = (nfreg_ff > NF_W'(NUM_FEATURES)) ?
                                NF_W'(NUM_FEATURES) : nfreg_ff;
                     scan_in  = '0;
                     if (count_ff == '0) begin
                        rsp_load      = 1'b1;
                        rsp_class_in  = '0;
                        rsp_status_in = STATUS_EMPTY;
                     end else if (CNT_W'(k_sat) > count_ff) begin
                        rsp_load      = 1'b1;
                        rsp_class_in  = '0;
                        rsp_status_in = STATUS_K_BIG;
                     end else begin
                        rank_clear = 1'b1;
                        state_in   = ST_SCAN;
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_SCAN: begin
            scan_in = scan_ff + 1'b1;
            if (CNT_W'(scan_ff) == count_ff - 1'b1)
               state_in = ST_DRAIN;
         end
         ST_DRAIN: begin
            if (!v1_ff && !v2_ff && !v3_ff) begin
               vote_start = 1'b1;
               state_in   = ST_VOTE;
            end
         end
         ST_VOTE: begin
            if (vote_done)
               state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_load      = 1'b1;
               rsp_class_in  = vote_class;
               rsp_status_in = STATUS_OK;
               state_in      = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
      if (rsp_load)
         rsp_valid_in = 1'b1;
      else if (rsp_tready)
         rsp_valid_in = 1'b0;
      else
         rsp_valid_in = rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         kreg_ff      <= K_W'(1);
         nfreg_ff     <= NF_W'(NUM_FEATURES);
         rsp_valid_ff <= 1'b0;
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         kreg_ff      <= kreg_in;
         nfreg_ff     <= nfreg_in;
         rsp_valid_ff <= rsp_valid_in;
         v1_ff        <= (state_ff == ST_SCAN);
         v2_ff        <= v1_ff;
         v3_ff        <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      scan_ff       <= scan_in;
      keff_ff       <= keff_in;
      nf_ff         <= nf_in;
      rsp_class_ff  <= rsp_class_in;
      rsp_status_ff <= rsp_status_in;
      if (accept && cmd == CMD_CLASSIFY)
         for (int f = 0; f < NUM_FEATURES; f++)
            query_ff[f] <= req_tdata[2 + f*FEAT_W +: FEAT_W];
   end

   // training store: one row holds the label above the eight features
   always_ff @(posedge clock) begin
      if (do_add)
         store_mem[count_ff[ADDR_W-1:0]] <= req_tdata[2 +: ROW_W];
      rd_ff <= store_mem[scan_ff];
   end

   for (genvar g = 0; g < NUM_FEATURES; g++) begin : g_lane
      knn_lane u_lane (
         .clock  (clock),
         .in_use (NF_W'(g) < nf_ff),
         .query  (query_ff[g]),
         .stored (rd_ff[g*FEAT_W +: FEAT_W]),
         .sq_ff  (sq[g])
      );
   end

   always_comb begin
      dist_sum = '0;
      for (int f = 0; f < NUM_FEATURES; f++)
         dist_sum = dist_sum + DIST_W'(sq[f]);
   end

   always_ff @(posedge clock) begin
      lab2_ff <= rd_ff[ROW_W-1 -: LABEL_W];
      lab3_ff <= lab2_ff;
      dist_ff <= dist_sum;
   end

   assign cand = '{valid: v3_ff, sq_dist: dist_ff, label: lab3_ff};

   knn_rank u_rank (
      .clock   (clock),
      .reset   (reset),
      .clear   (rank_clear),
      .cand    (cand),
      .k_eff   (keff_ff),
      .labels  (labels),
      .fill_ff (fill)
   );

   knn_vote u_vote (
      .clock    (clock),
      .reset    (reset),
      .start    (vote_start),
      .fill     (fill),
      .labels   (labels),
      .done_ff  (vote_done),
      .class_ff (vote_class)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'd0, rsp_status_ff, rsp_class_ff};

`ifndef ASSERT_OFF
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(TRAIN_DEPTH)) else $error("store count overflow");
   a_vote_full: assert property (@(posedge clock) disable iff (reset)
      vote_start |-> fill == keff_ff) else $error("fewer neighbours than k");
   a_done_state: assert property (@(posedge clock) disable iff (reset)
      vote_done |-> state_ff == ST_VOTE) else $error("vote ended outside vote");
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      rsp_load |-> (!rsp_valid_ff || rsp_tready)) else $error("response lost");
`endif
endmodule
`default_nettype wire
